// File: rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int FIELD_W   = 13;

    // hue positions carried as three times the hue
    localparam int T_W    = FIELD_W + 3;
    localparam int FACT_W = FRAC_BITS + 1;
    localparam int MUL_W  = FIELD_W + FIELD_W + 1;
    localparam int PQ_W   = FIELD_W + 5;
    localparam int D_W    = PQ_W + 1;
    localparam int PROD_W = D_W + FACT_W + 1;
    localparam int R_W    = PROD_W - FRAC_BITS + 1;

    localparam logic [FIELD_W-1:0]   ONE       = FIELD_W'(1 << FRAC_BITS);
    localparam logic [FIELD_W:0]     ONE_X     = (FIELD_W + 1)'(1 << FRAC_BITS);
    localparam logic signed [T_W-1:0] ONE_T    = T_W'(1 << FRAC_BITS);
    localparam logic signed [T_W-1:0] HALF_T   = T_W'((1 << FRAC_BITS) / 2);
    localparam logic signed [T_W-1:0] THREEHALF_T = T_W'(3 * (1 << FRAC_BITS) / 2);
    localparam logic signed [T_W-1:0] TWO_T    = T_W'(2 * (1 << FRAC_BITS));
    localparam logic signed [T_W-1:0] THREE_T  = T_W'(3 * (1 << FRAC_BITS));
    localparam logic signed [T_W:0]   FOUR_TX  = (T_W + 1)'(4 * (1 << FRAC_BITS));
    localparam logic signed [R_W-1:0] ONE_R    = R_W'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } seg_t;

endpackage

// File: rtl/hsl2rgb_ramp.sv
module hsl2rgb_ramp
    import hsl2rgb_pkg::*;
(
    input  logic                      clk,
    input  logic signed [T_W-1:0]     t3,
    input  logic signed [PQ_W-1:0]    p2,
    input  logic signed [PQ_W-1:0]    q2,
    input  logic signed [D_W-1:0]     d2,
    output logic [FIELD_W-1:0]        level
);

    logic signed [T_W-1:0]    tw_a;
    logic signed [T_W-1:0]    tw_b;
    logic signed [T_W:0]      dbl;
    logic signed [T_W:0]      fall_f;
    seg_t                     seg_next;
    logic [FACT_W-1:0]        fac_next;

    seg_t                     seg1_reg;
    logic [FACT_W-1:0]        fac1_reg;
    seg_t                     seg2_reg;
    logic [FACT_W-1:0]        fac2_reg;
    seg_t                     seg3_reg;
    logic signed [PROD_W-1:0] prod3_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PQ_W-1:0]   p3_reg;
    logic signed [PQ_W-1:0]   q3_reg;

    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-FRAC_BITS-1:0] sh;
    logic signed [R_W-1:0]    ramp_v;
    logic signed [R_W-1:0]    r;

    // wrap once each way, then pick the segment and ramp factor
    always_comb
    begin
        tw_a   = (t3 < 0) ? t3 + THREE_T : t3;
        tw_b   = (tw_a > THREE_T) ? tw_a - THREE_T : tw_a;
        dbl    = {tw_b, 1'b0};
        fall_f = FOUR_TX - dbl;
        priority if (tw_b < HALF_T)
        begin
            seg_next = SEG_RISE;
            fac_next = dbl[FACT_W-1:0];
        end
        else if (tw_b < THREEHALF_T)
        begin
            seg_next = SEG_HIGH;
            fac_next = '0;
        end
        else if (tw_b < TWO_T)
        begin
            seg_next = SEG_FALL;
            fac_next = fall_f[FACT_W-1:0];
        end
        else
        begin
            seg_next = SEG_LOW;
            fac_next = '0;
        end
    end

    assign prod_next = PROD_W'(d2) * PROD_W'($signed({1'b0, fac2_reg}));

    always_ff @(posedge clk)
    begin
        seg1_reg  <= seg_next;
        fac1_reg  <= fac_next;
        seg2_reg  <= seg1_reg;
        fac2_reg  <= fac1_reg;
        seg3_reg  <= seg2_reg;
        prod3_reg <= prod_next;
        p3_reg    <= p2;
        q3_reg    <= q2;
    end

    // shift toward zero, add to p, select segment, clamp
    always_comb
    begin
        neg    = prod3_reg[PROD_W-1];
        mag    = neg ? PROD_W'(-prod3_reg) : PROD_W'(prod3_reg);
        sh     = mag[PROD_W-1:FRAC_BITS];
        ramp_v = neg ? R_W'(p3_reg) - $signed({1'b0, sh})
                     : R_W'(p3_reg) + $signed({1'b0, sh});
        unique case (seg3_reg)
            SEG_RISE: r = ramp_v;
            SEG_FALL: r = ramp_v;
            SEG_HIGH: r = R_W'(q3_reg);
            SEG_LOW:  r = R_W'(p3_reg);
            default:  r = R_W'(p3_reg);
        endcase
        priority if (r < 0)
            level = '0;
        else if (r > ONE_R)
            level = ONE;
        else
            level = r[FIELD_W-1:0];
    end

endmodule

// File: rtl/hsl_to_rgb_converter_unit.sv
// channel   direction  handshake        fields
// command   in         start, busy      hue, saturation, lightness
// result    out        done             red, green, blue
//
// Four-stage pipeline: a word accepted with start moves through v1_reg to v4_reg
// and appears with done. One word can be taken every cycle, so busy stays low.
// rst_n clears the valid bits only; words in flight are dropped.
// The result side cannot stall, so nothing in the pipe ever waits.
module hsl_to_rgb_converter_unit
    import hsl2rgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FIELD_W-1:0]  hue,
    input  logic [FIELD_W-1:0]  saturation,
    input  logic [FIELD_W-1:0]  lightness,
    output logic                done,
    output logic [FIELD_W-1:0]  red,
    output logic [FIELD_W-1:0]  green,
    output logic [FIELD_W-1:0]  blue
);

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;

    logic                   low_next;
    logic [FIELD_W:0]       mul_b;
    logic [MUL_W-1:0]       prod1_next;
    logic [T_W-1:0]         h3;
    logic signed [T_W-1:0]  t_red, t_green, t_blue;

    logic [MUL_W-1:0]       prod1_reg;
    logic                   low1_reg;
    logic                   grey1_reg, grey2_reg, grey3_reg;
    logic [FIELD_W-1:0]     l1_reg, l2_reg, l3_reg;
    logic [FIELD_W-1:0]     s1_reg;

    logic [MUL_W-FRAC_BITS-1:0] qsh;
    logic signed [PQ_W-1:0] q_next, p_next;
    logic signed [D_W-1:0]  d_next;
    logic signed [PQ_W-1:0] p2_reg, q2_reg;
    logic signed [D_W-1:0]  d2_reg;

    logic [FIELD_W-1:0]     lvl_red, lvl_green, lvl_blue, lvl_grey;
    logic [FIELD_W-1:0]     red_reg, green_reg, blue_reg;

    assign busy = 1'b0;

    // stage 1: q product and hue positions
    always_comb
    begin
        low_next   = ({lightness, 1'b0} < ONE_X);
        mul_b      = low_next ? (ONE_X + (FIELD_W + 1)'(saturation))
                              : (FIELD_W + 1)'(saturation);
        prod1_next = MUL_W'(lightness) * MUL_W'(mul_b);
        h3         = T_W'({hue, 1'b0}) + T_W'(hue);
        t_green    = h3;
        t_red      = h3 + ONE_T;
        t_blue     = h3 - ONE_T;
    end

    // stage 2: bounds
    always_comb
    begin
        qsh    = prod1_reg[MUL_W-1:FRAC_BITS];
        q_next = low1_reg ? PQ_W'(qsh)
                          : PQ_W'(l1_reg) + PQ_W'(s1_reg) - PQ_W'(qsh);
        p_next = PQ_W'({l1_reg, 1'b0}) - q_next;
        d_next = D_W'(q_next) - D_W'(p_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        low1_reg  <= low_next;
        grey1_reg <= (saturation == '0);
        l1_reg    <= lightness;
        s1_reg    <= saturation;
        p2_reg    <= p_next;
        q2_reg    <= q_next;
        d2_reg    <= d_next;
        grey2_reg <= grey1_reg;
        l2_reg    <= l1_reg;
        grey3_reg <= grey2_reg;
        l3_reg    <= l2_reg;
        red_reg   <= grey3_reg ? lvl_grey : lvl_red;
        green_reg <= grey3_reg ? lvl_grey : lvl_green;
        blue_reg  <= grey3_reg ? lvl_grey : lvl_blue;
    end

    assign lvl_grey = (l3_reg > ONE) ? ONE : l3_reg;

    hsl2rgb_ramp u_ramp_red
    (
        .clk   (clk),
        .t3    (t_red),
        .p2    (p2_reg),
        .q2    (q2_reg),
        .d2    (d2_reg),
        .level (lvl_red)
    );

    hsl2rgb_ramp u_ramp_green
    (
        .clk   (clk),
        .t3    (t_green),
        .p2    (p2_reg),
        .q2    (q2_reg),
        .d2    (d2_reg),
        .level (lvl_green)
    );

    hsl2rgb_ramp u_ramp_blue
    (
        .clk   (clk),
        .t3    (t_blue),
        .p2    (p2_reg),
        .q2    (q2_reg),
        .d2    (d2_reg),
        .level (lvl_blue)
    );

    assign done  = v4_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("accepted word did not emerge after four cycles");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without a matching command");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
        else $error("channel above full scale");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(saturation, 4) == '0) |-> (red == green) && (green == blue))
        else $error("grey input gave unequal channels");

endmodule
